@@ hdl/assert_macros.svh @@
// Assertion macros used by the pileup counter controller RTL.
// Depends on clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define PBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PBC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ hdl/pbc_pkg.sv @@
// Package for the pileup base counter: sizes, codes, control structs.
// No dependencies.
`timescale 1ns / 1ps
package pbc_pkg;
  localparam int POSITIONS = 65536;
  localparam int POS_BITS = $clog2(POSITIONS);
  localparam int COUNT_BITS = 16;
  localparam int WORD_BITS = 4 * COUNT_BITS;
  localparam int LIM_W = (POS_BITS + 1 > 17) ? POS_BITS + 1 : 17;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] REG_CHROM = 2'd0;
  localparam logic [1:0] REG_BIS = 2'd1;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_N = 3'd4;
  localparam logic [2:0] BASE_DEL = 3'd5;
  localparam logic [2:0] CLASS_DEL = 3'd4;

  typedef struct packed {
    logic capture;
    logic clr_init;
    logic clr_wr;
    logic add_rd;
    logic add_wr;
    logic err_emit;
    logic fin_init;
    logic fin_rd;
    logic rep_step;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic add_err;
    logic add_cnt;
    logic fin_empty;
    logic fin_done;
    logic pipe_busy;
    logic rep_last;
  } stat_t;
endpackage

@@ hdl/pbc_ram.sv @@
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

@@ hdl/pbc_ctrl.sv @@
// Controller FSM of the pileup base counter.
// Depends on pbc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbc_ctrl
  import pbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] operation_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR = 3'd1;
  localparam logic [2:0] ST_CHK = 3'd2;
  localparam logic [2:0] ST_WR = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_REP = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          case (operation_i)
            OP_ADD: state_d = ST_CHK;
            OP_CLEAR: begin
              cmd_o.clr_init = 1'b1;
              state_d = ST_CLR;
            end
            OP_FINISH: begin
              cmd_o.fin_init = 1'b1;
              state_d = stat_i.fin_empty ? ST_REP : ST_FIN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_CHK: begin
        if (stat_i.add_err) begin
          cmd_o.err_emit = 1'b1;
          state_d = ST_IDLE;
        end else if (stat_i.add_cnt) begin
          cmd_o.add_rd = 1'b1;
          state_d = ST_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FIN: begin
        cmd_o.fin_rd = 1'b1;
        if (stat_i.fin_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = ST_REP;
      end
      ST_REP: begin
        cmd_o.rep_step = 1'b1;
        if (stat_i.rep_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  `PBC_ASSERT_NEXT(a_rep_ends, state_q == ST_REP && stat_i.rep_last, state_q == ST_IDLE)
  `PBC_ASSERT_NEXT(a_clr_ends, state_q == ST_CLR && stat_i.clr_done, state_q == ST_IDLE)
  `PBC_ASSERT_NEXT(a_wr_after_rd, cmd_o.add_rd, cmd_o.add_wr)
  `PBC_ASSERT(a_no_rd_wr_mix, !(cmd_o.fin_rd && (cmd_o.add_wr || cmd_o.clr_wr)))
endmodule

@@ hdl/pbc_dp.sv @@
// Datapath: config registers, item registers, store, totals, finish sums, results.
// Depends on pbc_pkg and pbc_ram.
`timescale 1ns / 1ps
module pbc_dp
  import pbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic [15:0] position_i,
  input  logic [2:0]  read_base_i,
  input  logic [2:0]  ref_base_i,
  input  logic        forward_strand_i,
  input  logic        conversion_base_i,
  output logic        result_valid_o,
  output logic        status_o,
  output logic [2:0]  base_class_o,
  output logic [31:0] observed_count_o,
  output logic [31:0] mismatch_count_o,
  output logic [31:0] error_sum_o,
  output logic [31:0] depth_sum_o,
  output logic        last_o
);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [31:0] SMAX = '1;

  logic [16:0] chrom_q;
  logic        bis_q;
  logic [15:0] pos_q;
  logic [2:0]  rd_q, rf_q;
  logic        fwd_q, conv_q;
  logic [POS_BITS-1:0] walk_q;
  logic [31:0] tot_q [5];
  logic [31:0] mis_q [4];
  logic [31:0] err_q, dep_q;
  logic        v1_q, v2_q;
  logic [COUNT_BITS:0]   d_q;
  logic [COUNT_BITS-1:0] hi_q, lo_q;
  logic [2:0]  k_q;

  logic [LIM_W-1:0] lim, pos_ext;
  logic [POS_BITS-1:0] item_addr;
  logic masked, drop, rd_cnt;
  logic [2:0] cls;
  logic [WORD_BITS-1:0] rdata, upd;
  logic [COUNT_BITS-1:0] c_ref, c_nref, c_fwd, c_rev, r, n;
  logic re, we;
  logic [POS_BITS-1:0] raddr, waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [COUNT_BITS+4:0] ten_hi, nine_d;
  logic conf;
  logic [32:0] err_s, dep_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chrom_q <= '0;
      bis_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_CHROM) chrom_q <= cfg_data_i;
      if (cfg_index_i == REG_BIS) bis_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_q <= position_i;
      rd_q <= read_base_i;
      rf_q <= ref_base_i;
      fwd_q <= forward_strand_i;
      conv_q <= conversion_base_i;
    end
  end

  assign lim = (LIM_W'(chrom_q) > LIM_W'(POSITIONS)) ? LIM_W'(POSITIONS) : LIM_W'(chrom_q);
  assign pos_ext = LIM_W'(pos_q);
  assign item_addr = pos_ext[POS_BITS-1:0];
  assign masked = conv_q ? (rd_q == BASE_T || rd_q == BASE_C)
                         : (rd_q == BASE_A || rd_q == BASE_G);
  assign drop = bis_q && masked;
  assign rd_cnt = (rd_q inside {BASE_A, BASE_C, BASE_G, BASE_T, BASE_DEL});
  assign cls = (rd_q == BASE_DEL) ? CLASS_DEL : rd_q;

  assign stat_o.add_err = !drop && (pos_ext >= lim);
  assign stat_o.add_cnt = !drop && (rf_q < BASE_N) && rd_cnt;
  assign stat_o.clr_done = (walk_q == '1);
  assign stat_o.fin_empty = (lim == '0);
  assign stat_o.fin_done = (LIM_W'(walk_q) == lim - LIM_W'(1));
  assign stat_o.pipe_busy = v1_q || v2_q;
  assign stat_o.rep_last = (k_q == CLASS_DEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (cmd_i.clr_init || cmd_i.fin_init) begin
      walk_q <= '0;
    end else if (cmd_i.clr_wr || cmd_i.fin_rd) begin
      walk_q <= walk_q + POS_BITS'(1);
    end
  end

  assign re = cmd_i.add_rd || cmd_i.fin_rd;
  assign raddr = cmd_i.add_rd ? item_addr : walk_q;
  assign we = cmd_i.add_wr || cmd_i.clr_wr;
  assign waddr = cmd_i.clr_wr ? walk_q : item_addr;
  assign wdata = cmd_i.clr_wr ? '0 : upd;

  pbc_ram #(.WIDTH(WORD_BITS), .DEPTH(POSITIONS)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign c_ref = rdata[COUNT_BITS-1:0];
  assign c_nref = rdata[2*COUNT_BITS-1:COUNT_BITS];
  assign c_fwd = rdata[3*COUNT_BITS-1:2*COUNT_BITS];
  assign c_rev = rdata[4*COUNT_BITS-1:3*COUNT_BITS];

  always_comb begin
    logic [COUNT_BITS-1:0] nr, nn, nf, nv;
    nr = c_ref;
    nn = c_nref;
    nf = c_fwd;
    nv = c_rev;
    if (rd_q == rf_q) begin
      if (nr != CMAX) nr = nr + COUNT_BITS'(1);
    end else begin
      if (nn != CMAX) nn = nn + COUNT_BITS'(1);
    end
    if (fwd_q) begin
      if (nf != CMAX) nf = nf + COUNT_BITS'(1);
    end else begin
      if (nv != CMAX) nv = nv + COUNT_BITS'(1);
    end
    upd = {nv, nf, nn, nr};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) tot_q[i] <= '0;
      for (int i = 0; i < 4; i++) mis_q[i] <= '0;
    end else if (cmd_i.clr_init) begin
      for (int i = 0; i < 5; i++) tot_q[i] <= '0;
      for (int i = 0; i < 4; i++) mis_q[i] <= '0;
    end else if (cmd_i.add_wr) begin
      for (int i = 0; i < 5; i++) begin
        if (cls == 3'(i) && tot_q[i] != SMAX) tot_q[i] <= tot_q[i] + 32'd1;
      end
      for (int i = 0; i < 4; i++) begin
        if (rd_q == 3'(i) && rd_q != rf_q && mis_q[i] != SMAX) mis_q[i] <= mis_q[i] + 32'd1;
      end
    end
  end

  // finish walk: stage 1 depth and majority, stage 2 confidence test and sums
  assign r = c_ref;
  assign n = c_nref;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.fin_rd;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      d_q <= {1'b0, r} + {1'b0, n};
      hi_q <= (r > n) ? r : n;
      lo_q <= (r > n) ? n : r;
    end
  end

  assign ten_hi = ((COUNT_BITS+5)'(hi_q) << 3) + ((COUNT_BITS+5)'(hi_q) << 1);
  assign nine_d = ((COUNT_BITS+5)'(d_q) << 3) + (COUNT_BITS+5)'(d_q);
  assign conf = (d_q >= (COUNT_BITS+1)'(5)) && (ten_hi >= nine_d);
  assign err_s = {1'b0, err_q} + 33'(lo_q);
  assign dep_s = {1'b0, dep_q} + 33'(d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
      dep_q <= '0;
    end else if (cmd_i.clr_init || cmd_i.fin_init) begin
      err_q <= '0;
      dep_q <= '0;
    end else if (v2_q && conf) begin
      err_q <= err_s[32] ? SMAX : err_s[31:0];
      dep_q <= dep_s[32] ? SMAX : dep_s[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.fin_init) begin
      k_q <= '0;
    end else if (cmd_i.rep_step) begin
      k_q <= k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.rep_step || cmd_i.err_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_emit) begin
      status_o <= 1'b1;
      base_class_o <= BASE_A;
      observed_count_o <= '0;
      mismatch_count_o <= '0;
      error_sum_o <= '0;
      depth_sum_o <= '0;
      last_o <= 1'b1;
    end else if (cmd_i.rep_step) begin
      status_o <= 1'b0;
      base_class_o <= k_q;
      observed_count_o <= tot_q[k_q];
      mismatch_count_o <= (k_q < CLASS_DEL) ? mis_q[k_q[1:0]] : '0;
      error_sum_o <= stat_o.rep_last ? err_q : '0;
      depth_sum_o <= stat_o.rep_last ? dep_q : '0;
      last_o <= stat_o.rep_last;
    end
  end
endmodule

@@ hdl/pileup_base_counter.sv @@
// Pileup base counter top: add base does a read-modify-write on the store port,
// out-of-range add gives one result; clear writes all POSITIONS rows, one row a cycle;
// finish walks min(chrom_length,POSITIONS) rows, drains the pipeline, then gives 5 results.
// Reset clears all POSITIONS rows with busy high; config accepted anytime.
// Results strobe once on result_valid_o; the receiver cannot stall.
`timescale 1ns / 1ps
module pileup_base_counter
  import pbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] position_i,
  input  logic [2:0]  read_base_i,
  input  logic [2:0]  ref_base_i,
  input  logic        forward_strand_i,
  input  logic        conversion_base_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output logic        result_valid_o,
  output logic        status_o,
  output logic [2:0]  base_class_o,
  output logic [31:0] observed_count_o,
  output logic [31:0] mismatch_count_o,
  output logic [31:0] error_sum_o,
  output logic [31:0] depth_sum_o,
  output logic        last_o
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  pbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  pbc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .position_i        (position_i),
    .read_base_i       (read_base_i),
    .ref_base_i        (ref_base_i),
    .forward_strand_i  (forward_strand_i),
    .conversion_base_i (conversion_base_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .base_class_o      (base_class_o),
    .observed_count_o  (observed_count_o),
    .mismatch_count_o  (mismatch_count_o),
    .error_sum_o       (error_sum_o),
    .depth_sum_o       (depth_sum_o),
    .last_o            (last_o)
  );
endmodule

@@ dv/tb_pileup_base_counter.sv @@
// Self-checking testbench for pileup_base_counter: directed and random add/clear/finish beats.
// Predicts per-position pileup counts and class totals in SV; depends on pbc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_pileup_base_counter;
  import pbc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] pos;
    logic [2:0]  rd;
    logic [2:0]  rf;
    logic        fwd;
    logic        conv;
  } beat_t;

  typedef struct {
    logic        status;
    logic [2:0]  cls;
    logic [31:0] obs;
    logic [31:0] mis;
    logic [31:0] err;
    logic [31:0] dep;
    logic        last;
  } report_t;

  typedef struct {
    logic [15:0] ref_n;
    logic [15:0] alt_n;
  } pile_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [15:0] position_i = '0;
  logic [2:0]  read_base_i = '0;
  logic [2:0]  ref_base_i = '0;
  logic        forward_strand_i = 1'b0;
  logic        conversion_base_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic        status_o;
  logic [2:0]  base_class_o;
  logic [31:0] observed_count_o;
  logic [31:0] mismatch_count_o;
  logic [31:0] error_sum_o;
  logic [31:0] depth_sum_o;
  logic        last_o;

  pileup_base_counter dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  beat_t       pend_q[$];
  report_t     report_q[$];
  pile_t       pile[int];
  logic [31:0] class_tot[5];
  logic [31:0] class_mis[4];
  logic [16:0] chrom_len = '0;
  logic        bis_mode = 1'b0;
  int          errors = 0;
  bit          beat_taken = 0;
  bit          no_idle = 0;
  int          gap = 0;
  int          clears_left = 2;
  logic [2:0]  site_ref[64];

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [15:0] sat16_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_pileup();
    pile.delete();
    foreach (class_tot[k]) class_tot[k] = '0;
    foreach (class_mis[k]) class_mis[k] = '0;
  endfunction

  function automatic void tally_base(beat_t b);
    report_t r;
    pile_t   c;
    logic    masked;
    int      cls;
    masked = b.conv ? (b.rd == BASE_T || b.rd == BASE_C) : (b.rd == BASE_A || b.rd == BASE_G);
    if (bis_mode && masked) return;
    if ({1'b0, b.pos} >= chrom_len) begin
      r = '{1'b1, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
      report_q.insert(report_q.size(), r);
      return;
    end
    if (b.rf >= BASE_N) return;
    if (!(b.rd <= BASE_T || b.rd == BASE_DEL)) return;
    c = '{16'd0, 16'd0};
    if (pile.exists(b.pos)) c = pile[b.pos];
    if (b.rd == b.rf) c.ref_n = sat16_inc(c.ref_n);
    else c.alt_n = sat16_inc(c.alt_n);
    pile[b.pos] = c;
    cls = (b.rd == BASE_DEL) ? CLASS_DEL : b.rd;
    class_tot[cls] = sat32({32'd0, class_tot[cls]} + 64'd1);
    if (b.rd <= BASE_T && b.rd != b.rf) class_mis[b.rd] = sat32({32'd0, class_mis[b.rd]} + 64'd1);
  endfunction

  function automatic void summarize_pileup();
    logic [31:0] err_acc;
    logic [31:0] dep_acc;
    logic [63:0] d, hi, lo;
    report_t     r;
    err_acc = '0;
    dep_acc = '0;
    foreach (pile[p]) begin
      if (p < chrom_len) begin
        d = pile[p].ref_n + pile[p].alt_n;
        hi = (pile[p].ref_n > pile[p].alt_n) ? pile[p].ref_n : pile[p].alt_n;
        lo = (pile[p].ref_n > pile[p].alt_n) ? pile[p].alt_n : pile[p].ref_n;
        if (d >= 5 && 10 * hi >= 9 * d) begin
          err_acc = sat32({32'd0, err_acc} + lo);
          dep_acc = sat32({32'd0, dep_acc} + d);
        end
      end
    end
    for (int k = 0; k < 5; k++) begin
      r.status = 1'b0;
      r.cls = 3'(k);
      r.obs = class_tot[k];
      r.mis = (k < 4) ? class_mis[k] : 32'd0;
      r.err = (k == 4) ? err_acc : 32'd0;
      r.dep = (k == 4) ? dep_acc : 32'd0;
      r.last = (k == 4);
      report_q.insert(report_q.size(), r);
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    beat_t b;
    logic  nxt;
    nxt = start;
    if (rst_ni && (!start || beat_taken)) begin
      beat_taken = 0;
      nxt = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (pend_q.size() > 0) begin
        if (!no_idle && $urandom_range(0, 4) == 0) begin
          gap = $urandom_range(1, 10) - 1;
        end else begin
          b = pend_q.pop_front();
          operation_i <= b.op;
          position_i <= b.pos;
          read_base_i <= b.rd;
          ref_base_i <= b.rf;
          forward_strand_i <= b.fwd;
          conversion_base_i <= b.conv;
          nxt = 1'b1;
        end
      end
    end
    start <= nxt;
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    report_t e;
    beat_t   b;
    if (rst_ni && result_valid_o) begin
      if (report_q.size() == 0) begin
        $error("unexpected result beat class=%0d", base_class_o);
        errors++;
      end else begin
        e = report_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (base_class_o !== e.cls) begin
          $error("base_class exp %0d got %0d", e.cls, base_class_o); errors++;
        end
        if (observed_count_o !== e.obs) begin
          $error("observed_count exp %0d got %0d", e.obs, observed_count_o); errors++;
        end
        if (mismatch_count_o !== e.mis) begin
          $error("mismatch_count exp %0d got %0d", e.mis, mismatch_count_o); errors++;
        end
        if (error_sum_o !== e.err) begin
          $error("error_sum exp %0d got %0d", e.err, error_sum_o); errors++;
        end
        if (depth_sum_o !== e.dep) begin
          $error("depth_sum exp %0d got %0d", e.dep, depth_sum_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      beat_taken = 1;
      b = '{operation_i, position_i, read_base_i, ref_base_i, forward_strand_i,
            conversion_base_i};
      case (b.op)
        OP_ADD: tally_base(b);
        OP_CLEAR: clear_pileup();
        OP_FINISH: summarize_pileup();
        default: ;
      endcase
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || start || busy || report_q.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == REG_CHROM) chrom_len = val;
    else bis_mode = val[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push(logic [1:0] op, logic [15:0] pos, logic [2:0] rd, logic [2:0] rf,
                      logic fwd, logic conv);
    beat_t b;
    b = '{op, pos, rd, rf, fwd, conv};
    pend_q.insert(pend_q.size(), b);
  endtask

  task automatic random_phase(int n, logic [15:0] base);
    logic [15:0] p;
    int          sel;
    logic [1:0]  op;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      op = OP_ADD;
      if (sel < 6) op = OP_FINISH;
      else if (sel < 8) op = OP_UNUSED;
      else if (sel < 9 && clears_left > 0) begin
        op = OP_CLEAR;
        clears_left--;
      end
      if ($urandom_range(0, 9) == 0) p = 16'($urandom);
      else p = base + 16'($urandom_range(0, 63));
      if ($urandom_range(0, 9) < 8)
        push(op, p,
             ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : site_ref[p[5:0]],
             site_ref[p[5:0]], 1'($urandom), 1'($urandom));
      else
        push(op, p, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 1'($urandom),
             1'($urandom));
    end
    push(OP_FINISH, '0, BASE_A, BASE_A, 1'b0, 1'b0);
  endtask

  initial begin
    logic [16:0] lens[6];
    clear_pileup();
    foreach (site_ref[k]) site_ref[k] = 3'($urandom_range(0, 3));
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_CHROM, 17'd20);
    write_reg(REG_BIS, 17'd0);
    push(OP_FINISH, 16'd0, BASE_A, BASE_A, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) push(OP_ADD, 16'd0, BASE_C, BASE_C, i[0], 1'b0);
    push(OP_ADD, 16'd0, BASE_T, BASE_C, 1'b1, 1'b1);
    push(OP_ADD, 16'd19, BASE_DEL, BASE_G, 1'b0, 1'b0);
    push(OP_ADD, 16'd19, BASE_N, BASE_G, 1'b1, 1'b0);
    push(OP_ADD, 16'd20, BASE_A, BASE_A, 1'b1, 1'b0);
    push(OP_ADD, 16'hFFFF, 3'd7, 3'd7, 1'b1, 1'b1);
    push(OP_ADD, 16'd3, BASE_G, BASE_N, 1'b0, 1'b0);
    push(OP_ADD, 16'd3, BASE_A, 3'd7, 1'b0, 1'b0);
    push(OP_UNUSED, 16'd3, BASE_A, BASE_A, 1'b0, 1'b0);
    push(OP_FINISH, 16'd0, BASE_A, BASE_A, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_BIS, 17'd1);
    push(OP_ADD, 16'd30, BASE_G, BASE_A, 1'b1, 1'b0);
    push(OP_ADD, 16'd2, BASE_T, BASE_A, 1'b1, 1'b1);
    push(OP_ADD, 16'd2, BASE_A, BASE_A, 1'b0, 1'b1);
    push(OP_ADD, 16'd2, BASE_DEL, BASE_A, 1'b0, 1'b0);
    push(OP_FINISH, 16'd0, BASE_A, BASE_A, 1'b0, 1'b0);
    push(OP_CLEAR, 16'd0, BASE_A, BASE_A, 1'b0, 1'b0);
    push(OP_FINISH, 16'd0, BASE_A, BASE_A, 1'b0, 1'b0);
    wait_idle();

    lens = '{17'd0, 17'd1, 17'd40, 17'd300, 17'd65535, 17'd65536};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_CHROM, (ph < 6) ? lens[ph] : 17'd64);
      write_reg(REG_BIS, 17'($urandom_range(0, 1)));
      if (ph == 6) no_idle = 1;
      random_phase(ph >= 4 && ph < 6 ? 40 : 75, (ph >= 4 && ph < 6) ? 16'hFFC0 : 16'd0);
      wait_idle();
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("PASS pileup_base_counter");
    else $display("FAIL pileup_base_counter");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL pileup_base_counter");
    $finish;
  end
endmodule
